// File: rtl/core/bcld_pkg.sv
// Shared types and constants of the bytecode length decoder.
package bcld_pkg;

  // Largest total length that a switch instruction may reach.
  localparam int unsigned CODE_LIMIT = 65535;

  // Opcodes that the decoder treats by name.
  localparam logic [7:0] OP_TABLESWITCH  = 8'hAA;
  localparam logic [7:0] OP_LOOKUPSWITCH = 8'hAB;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNDEF_OP   = 3'd1,
    ST_BAD_ATYPE  = 3'd2,
    ST_BAD_WIDE   = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_BAD_BOUNDS = 3'd5
  } status_e;

  // Kind of instruction selected by an opcode byte.
  typedef enum logic [2:0] {
    KIND_UNDEF,
    KIND_FIXED,
    KIND_NEWARRAY,
    KIND_WIDE,
    KIND_TABLESWITCH,
    KIND_LOOKUPSWITCH
  } op_kind_e;

  // Decoder phase, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_FIXED    = 9'b000000010,
    PH_NEWARRAY = 9'b000000100,
    PH_WIDE     = 9'b000001000,
    PH_PAD      = 9'b000010000,
    PH_DEF      = 9'b000100000,
    PH_LOW      = 9'b001000000,
    PH_HIGH     = 9'b010000000,
    PH_TABLE    = 9'b100000000
  } phase_e;

  // Everything the decoder needs to know about one code byte.
  typedef struct packed {
    op_kind_e   kind;
    logic [2:0] fixed_len;   // total length of a fixed-size instruction
    logic       atype_ok;    // valid newarray element type
    logic       wide_short;  // wide load, store or ret target
    logic       wide_iinc;   // wide iinc target
  } byte_class_t;

  // Outcome of the switch length check.
  typedef struct packed {
    logic bad;    // bounds out of order, negative pair count or total too long
    logic empty;  // no table bytes follow
  } bounds_flags_t;

endpackage

// File: rtl/core/bcld_intf.sv
// Handshake channels for code bytes and decoded instruction results.
interface bcld_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       stream_end;

  modport source (output valid, output code_byte, output stream_end, input ready);
  modport sink (input valid, input code_byte, input stream_end, output ready);
endinterface

interface bcld_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_offset;
  logic [7:0]  opcode;
  logic [15:0] instr_length;
  logic [2:0]  status;

  modport source (
    output valid, output instr_offset, output opcode, output instr_length,
    output status, input ready
  );
  modport sink (
    input valid, input instr_offset, input opcode, input instr_length,
    input status, output ready
  );
endinterface

// File: rtl/core/bcld_opdec.sv
// Classifies one code byte as opcode, newarray type or wide target.
module bcld_opdec (
  input  logic [7:0]           byte_i,
  output bcld_pkg::byte_class_t class_o
);
  import bcld_pkg::*;

  // Opcode table following the JVM numbering, plus operand checks for newarray and wide.
  always_comb begin
    class_o.kind       = KIND_FIXED;
    class_o.fixed_len  = 3'd1;
    class_o.atype_ok   = (byte_i inside {[8'd4:8'd11]});
    class_o.wide_short = (byte_i inside {[8'h15:8'h19], [8'h36:8'h3A], 8'hA9});
    class_o.wide_iinc  = (byte_i == 8'h84);
    case (byte_i) inside
      [8'h00:8'h0F]: class_o.fixed_len = 3'd1;
      8'h10:         class_o.fixed_len = 3'd2;
      8'h11:         class_o.fixed_len = 3'd3;
      8'h12:         class_o.fixed_len = 3'd2;
      [8'h13:8'h14]: class_o.fixed_len = 3'd3;
      [8'h15:8'h19]: class_o.fixed_len = 3'd2;
      [8'h1A:8'h35]: class_o.fixed_len = 3'd1;
      [8'h36:8'h3A]: class_o.fixed_len = 3'd2;
      [8'h3B:8'h83]: class_o.fixed_len = 3'd1;
      8'h84:         class_o.fixed_len = 3'd3;
      [8'h85:8'h98]: class_o.fixed_len = 3'd1;
      [8'h99:8'hA8]: class_o.fixed_len = 3'd3;
      8'hA9:         class_o.fixed_len = 3'd2;
      8'hAA:         class_o.kind = KIND_TABLESWITCH;
      8'hAB:         class_o.kind = KIND_LOOKUPSWITCH;
      [8'hAC:8'hB1]: class_o.fixed_len = 3'd1;
      [8'hB2:8'hB8]: class_o.fixed_len = 3'd3;
      8'hB9:         class_o.fixed_len = 3'd5;
      8'hBA:         class_o.fixed_len = 3'd1;
      8'hBB:         class_o.fixed_len = 3'd3;
      8'hBC:         class_o.kind = KIND_NEWARRAY;
      8'hBD:         class_o.fixed_len = 3'd3;
      [8'hBE:8'hBF]: class_o.fixed_len = 3'd1;
      [8'hC0:8'hC1]: class_o.fixed_len = 3'd3;
      [8'hC2:8'hC3]: class_o.fixed_len = 3'd1;
      8'hC4:         class_o.kind = KIND_WIDE;
      8'hC5:         class_o.fixed_len = 3'd4;
      [8'hC6:8'hC7]: class_o.fixed_len = 3'd3;
      [8'hC8:8'hC9]: class_o.fixed_len = 3'd5;
      8'hCA:         class_o.fixed_len = 3'd1;
      [8'hFE:8'hFF]: class_o.fixed_len = 3'd1;
      default:       class_o.kind = KIND_UNDEF;
    endcase
  end

endmodule

// File: rtl/core/bcld_bounds.sv
// Checks switch bounds and works out the number of table bytes.
module bcld_bounds #(
  parameter int unsigned CodeLimit = bcld_pkg::CODE_LIMIT,
  localparam int unsigned LenW     = $clog2(CodeLimit + 1)
) (
  input  logic                    is_table_i,
  input  logic [31:0]             low_i,
  input  logic [31:0]             high_i,
  input  logic [LenW-1:0]         len_i,
  output bcld_pkg::bounds_flags_t flags_o,
  output logic [LenW-1:0]         bytes_o
);
  import bcld_pkg::*;

  localparam int unsigned SumW = LenW + 4;

  logic [32:0]     diff;
  logic            tbl_neg;
  logic            tbl_big;
  logic [SumW-1:0] tbl_bytes;
  logic            lk_neg;
  logic            lk_big;
  logic [SumW-1:0] lk_bytes;
  logic [SumW-1:0] bytes;
  logic [SumW-1:0] total;

  // Tableswitch: four bytes for each entry from low to high.
  always_comb begin
    diff      = {high_i[31], high_i} - {low_i[31], low_i};
    tbl_neg   = diff[32];
    tbl_big   = |diff[31:LenW];
    tbl_bytes = SumW'({diff[LenW-1:0], 2'b00}) + SumW'(4);
  end

  // Lookupswitch: eight bytes for each pair.
  always_comb begin
    lk_neg   = high_i[31];
    lk_big   = |high_i[30:LenW];
    lk_bytes = SumW'({high_i[LenW-1:0], 3'b000});
  end

  // Total length against the code limit.
  always_comb begin
    bytes         = is_table_i ? tbl_bytes : lk_bytes;
    total         = bytes + SumW'(len_i);
    flags_o.bad   = (is_table_i ? (tbl_neg || tbl_big) : (lk_neg || lk_big)) ||
                    (total > SumW'(CodeLimit));
    flags_o.empty = !is_table_i && (high_i == 32'd0);
    bytes_o       = bytes[LenW-1:0];
  end

endmodule

// File: rtl/core/bytecode_length_decoder_top.sv
// Top level of the bytecode length decoder: input stage, decode state, result register.
// Code words are held in the input stage, finished results in the result register.
// Throughput: one code word per cycle unless the sink stalls; the input stage and the
// result register each hold one word, so one more word is taken while a result waits.
// Reset clears the pipeline, the start offset to zero and the decoder to wait for an opcode.
module bytecode_length_decoder_top #(
  parameter int unsigned CodeLimit = bcld_pkg::CODE_LIMIT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_offset_we_i,
  input  logic [15:0]          start_offset_i,
  bcld_code_if.sink            code_i,
  bcld_result_if.source        result_o
);
  import bcld_pkg::*;

  localparam int unsigned LenW = $clog2(CodeLimit + 1);

  // Input stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       step;

  // Decoder state.
  logic [15:0]     start_off_q;
  logic [15:0]     run_off_q, run_off_d;
  logic [15:0]     instr_start_q, instr_start_d;
  logic [7:0]      cur_op_q, cur_op_d;
  phase_e          phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [31:0]     word_q, word_d;
  logic [31:0]     low_q, low_d;
  logic [LenW-1:0] tbl_q, tbl_d;
  logic [LenW-1:0] len_q, len_d;
  logic            err_q, err_d;

  // Result register.
  logic            out_valid_q;
  logic [15:0]     out_off_q, out_off_d;
  logic [7:0]      out_op_q, out_op_d;
  logic [15:0]     out_len_q, out_len_d;
  status_e         out_st_q, out_st_d;
  logic            emit;

  byte_class_t     bclass;
  bounds_flags_t   bflags;
  logic [LenW-1:0] bbytes;
  logic [LenW-1:0] len_inc;
  logic [31:0]     word_shift;

  // A word advances when the result register is free or drains this cycle.
  assign step         = in_valid_q && (!out_valid_q || result_o.ready);
  assign code_i.ready = !in_valid_q || step;

  assign len_inc    = len_q + LenW'(1);
  assign word_shift = {word_q[23:0], in_byte_q};

  bcld_opdec u_opdec (
    .byte_i  (in_byte_q),
    .class_o (bclass)
  );

  bcld_bounds #(
    .CodeLimit (CodeLimit)
  ) u_bounds (
    .is_table_i (cur_op_q == OP_TABLESWITCH),
    .low_i      (low_q),
    .high_i     (word_shift),
    .len_i      (len_inc),
    .flags_o    (bflags),
    .bytes_o    (bbytes)
  );

  // Next state and result for the word in the input stage.
  always_comb begin
    run_off_d     = run_off_q;
    instr_start_d = instr_start_q;
    cur_op_d      = cur_op_q;
    phase_d       = phase_q;
    cnt_d         = cnt_q;
    word_d        = word_q;
    low_d         = low_q;
    tbl_d         = tbl_q;
    len_d         = len_q;
    err_d         = err_q;
    emit          = 1'b0;
    out_off_d     = instr_start_q;
    out_op_d      = cur_op_q;
    out_len_d     = 16'd0;
    out_st_d      = ST_OK;

    if (in_end_q) begin
      // End of stream reports a partial instruction and restarts.
      if (!err_q && (phase_q != PH_IDLE)) begin
        emit     = 1'b1;
        out_st_d = ST_TRUNCATED;
      end
      run_off_d = start_off_q;
      phase_d   = PH_IDLE;
      err_d     = 1'b0;
    end else begin
      run_off_d = run_off_q + 16'd1;
      if (!err_q) begin
        len_d = len_inc;
        case (phase_q)
          PH_IDLE: begin
            instr_start_d = run_off_q;
            cur_op_d      = in_byte_q;
            len_d         = LenW'(1);
            out_off_d     = run_off_q;
            out_op_d      = in_byte_q;
            case (bclass.kind)
              KIND_UNDEF: begin
                emit     = 1'b1;
                out_st_d = ST_UNDEF_OP;
              end
              KIND_FIXED: begin
                if (bclass.fixed_len == 3'd1) begin
                  emit      = 1'b1;
                  out_len_d = 16'd1;
                end else begin
                  cnt_d   = bclass.fixed_len - 3'd1;
                  phase_d = PH_FIXED;
                end
              end
              KIND_NEWARRAY: phase_d = PH_NEWARRAY;
              KIND_WIDE:     phase_d = PH_WIDE;
              default: begin
                // Switches pad to a four-byte boundary after the opcode.
                word_d = 32'd0;
                if (run_off_q[1:0] != 2'b11) begin
                  cnt_d   = {1'b0, ~run_off_q[1:0]};
                  phase_d = PH_PAD;
                end else begin
                  cnt_d   = 3'd4;
                  phase_d = PH_DEF;
                end
              end
            endcase
          end
          PH_FIXED: begin
            cnt_d = cnt_q - 3'd1;
            if (cnt_q == 3'd1) begin
              emit      = 1'b1;
              out_len_d = 16'(len_inc);
            end
          end
          PH_NEWARRAY: begin
            emit = 1'b1;
            if (bclass.atype_ok) begin
              out_len_d = 16'(len_inc);
            end else begin
              out_st_d = ST_BAD_ATYPE;
            end
          end
          PH_WIDE: begin
            phase_d = PH_FIXED;
            if (bclass.wide_short) begin
              cnt_d = 3'd2;
            end else if (bclass.wide_iinc) begin
              cnt_d = 3'd4;
            end else begin
              emit     = 1'b1;
              out_st_d = ST_BAD_WIDE;
            end
          end
          PH_PAD: begin
            cnt_d = cnt_q - 3'd1;
            if (cnt_q == 3'd1) begin
              cnt_d   = 3'd4;
              phase_d = PH_DEF;
            end
          end
          PH_DEF, PH_LOW, PH_HIGH: begin
            // Gather a big-endian word, then act on it.
            word_d = word_shift;
            cnt_d  = cnt_q - 3'd1;
            if (cnt_q == 3'd1) begin
              cnt_d = 3'd4;
              if (phase_q == PH_DEF) begin
                word_d  = 32'd0;
                phase_d = (cur_op_q == OP_TABLESWITCH) ? PH_LOW : PH_HIGH;
              end else if (phase_q == PH_LOW) begin
                low_d   = word_shift;
                word_d  = 32'd0;
                phase_d = PH_HIGH;
              end else begin
                cnt_d = 3'd0;
                if (bflags.bad) begin
                  emit     = 1'b1;
                  out_st_d = ST_BAD_BOUNDS;
                end else if (bflags.empty) begin
                  emit      = 1'b1;
                  out_len_d = 16'(len_inc);
                end else begin
                  tbl_d   = bbytes;
                  phase_d = PH_TABLE;
                end
              end
            end
          end
          PH_TABLE: begin
            tbl_d = tbl_q - LenW'(1);
            if (tbl_q == LenW'(1)) begin
              emit      = 1'b1;
              out_len_d = 16'(len_inc);
            end
          end
          default: phase_d = PH_IDLE;
        endcase
        if (emit) begin
          phase_d = PH_IDLE;
          if (out_st_d != ST_OK) begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (code_i.ready) begin
      in_valid_q <= code_i.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (code_i.valid && code_i.ready) begin
      in_byte_q <= code_i.code_byte;
      in_end_q  <= code_i.stream_end;
    end
  end

  // Decoder control state; a start offset write restarts the decoder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_off_q <= 16'd0;
      run_off_q   <= 16'd0;
      phase_q     <= PH_IDLE;
      err_q       <= 1'b0;
    end else if (start_offset_we_i) begin
      start_off_q <= start_offset_i;
      run_off_q   <= start_offset_i;
      phase_q     <= PH_IDLE;
      err_q       <= 1'b0;
    end else if (step) begin
      run_off_q <= run_off_d;
      phase_q   <= phase_d;
      err_q     <= err_d;
    end
  end

  // Decoder working registers.
  always_ff @(posedge clk_i) begin
    if (step) begin
      instr_start_q <= instr_start_d;
      cur_op_q      <= cur_op_d;
      cnt_q         <= cnt_d;
      word_q        <= word_d;
      low_q         <= low_d;
      tbl_q         <= tbl_d;
      len_q         <= len_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= emit;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_off_q <= out_off_d;
      out_op_q  <= out_op_d;
      out_len_q <= out_len_d;
      out_st_q  <= out_st_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.instr_offset = out_off_q;
  assign result_o.opcode       = out_op_q;
  assign result_o.instr_length = out_len_q;
  assign result_o.status       = out_st_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the bytecode length decoder: stimulus, prediction and checks.
`timescale 1ns / 100ps

module tb;
  import bcld_pkg::*;

  // Opcodes and element types that the stimulus and the predictor use by name.
  localparam logic [7:0] OP_NOP           = 8'h00;
  localparam logic [7:0] OP_SIPUSH        = 8'h11;
  localparam logic [7:0] OP_ILOAD         = 8'h15;
  localparam logic [7:0] OP_ALOAD         = 8'h19;
  localparam logic [7:0] OP_ISTORE        = 8'h36;
  localparam logic [7:0] OP_ASTORE        = 8'h3A;
  localparam logic [7:0] OP_IINC          = 8'h84;
  localparam logic [7:0] OP_RET           = 8'hA9;
  localparam logic [7:0] OP_INVOKEDYNAMIC = 8'hBA;
  localparam logic [7:0] OP_NEWARRAY      = 8'hBC;
  localparam logic [7:0] OP_WIDE          = 8'hC4;
  localparam logic [7:0] OP_BREAKPOINT    = 8'hCA;
  localparam logic [7:0] OP_UNDEF_FIRST   = 8'hCB;
  localparam logic [7:0] OP_UNDEF_LAST    = 8'hFD;
  localparam logic [7:0] OP_IMPDEP1       = 8'hFE;
  localparam logic [7:0] OP_IMPDEP2       = 8'hFF;
  localparam logic [7:0] ATYPE_FIRST      = 8'd4;
  localparam logic [7:0] ATYPE_LAST       = 8'd11;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WORD_TARGET    = 1450;
  localparam int MAX_REPORTS    = 10;

  // How the bound words of a switch instruction are chosen.
  typedef enum int {BND_NORMAL, BND_EMPTY, BND_INVERTED, BND_OVERSIZE} bound_mode_e;

  typedef struct packed {
    logic [15:0] off;
    logic [7:0]  op;
    logic [15:0] len;
    status_e     st;
  } instr_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_offset_we;
  logic [15:0] start_offset_val;

  bcld_code_if   code_if ();
  bcld_result_if res_if ();

  bytecode_length_decoder_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_offset_we_i (start_offset_we),
    .start_offset_i    (start_offset_val),
    .code_i            (code_if),
    .result_o          (res_if)
  );

  // Decoder state as predicted from the accepted words.
  logic [15:0] start_reg;
  logic [15:0] run_off;
  logic [15:0] ins_start;
  logic [7:0]  cur_op;
  phase_e      ph;
  logic [3:0]  fix_left;
  logic [31:0] word_acc;
  logic [31:0] low_word;
  logic [16:0] tbl_left;
  logic [15:0] len_acc;
  logic        err_hold;

  instr_res_t expected_instrs[$];

  bit throttle;
  int words_sent;
  int streams_sent;
  int offset_writes;
  int results_seen;
  int err_count;
  int idle_cycles;
  int status_seen[6];

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Length class of an opcode byte; flen is the total length of a fixed-size instruction.
  function automatic op_kind_e opcode_kind(input logic [7:0] op, output int unsigned flen);
    op_kind_e k;
    k = KIND_FIXED;
    flen = 0;
    if (op <= 8'h0F) flen = 1;
    else if (op == 8'h10) flen = 2;
    else if (op == OP_SIPUSH) flen = 3;
    else if (op == 8'h12) flen = 2;
    else if (op <= 8'h14) flen = 3;
    else if (op <= OP_ALOAD) flen = 2;
    else if (op <= 8'h35) flen = 1;
    else if (op <= OP_ASTORE) flen = 2;
    else if (op < OP_IINC) flen = 1;
    else if (op == OP_IINC) flen = 3;
    else if (op <= 8'h98) flen = 1;
    else if (op < OP_RET) flen = 3;
    else if (op == OP_RET) flen = 2;
    else if (op == OP_TABLESWITCH) k = KIND_TABLESWITCH;
    else if (op == OP_LOOKUPSWITCH) k = KIND_LOOKUPSWITCH;
    else if (op <= 8'hB1) flen = 1;
    else if (op <= 8'hB8) flen = 3;
    else if (op == 8'hB9) flen = 5;
    else if (op == OP_INVOKEDYNAMIC) flen = 1;
    else if (op == 8'hBB) flen = 3;
    else if (op == OP_NEWARRAY) k = KIND_NEWARRAY;
    else if (op == 8'hBD) flen = 3;
    else if (op <= 8'hBF) flen = 1;
    else if (op <= 8'hC1) flen = 3;
    else if (op < OP_WIDE) flen = 1;
    else if (op == OP_WIDE) k = KIND_WIDE;
    else if (op == 8'hC5) flen = 4;
    else if (op <= 8'hC7) flen = 3;
    else if (op <= 8'hC9) flen = 5;
    else if (op == OP_BREAKPOINT || op >= OP_IMPDEP1) flen = 1;
    else k = KIND_UNDEF;
    return k;
  endfunction

  function automatic void restart_decoder();
    run_off   = start_reg;
    ins_start = '0;
    cur_op    = '0;
    ph        = PH_IDLE;
    fix_left  = '0;
    word_acc  = '0;
    low_word  = '0;
    tbl_left  = '0;
    len_acc   = '0;
    err_hold  = 1'b0;
  endfunction

  // Queue one finished instruction; any status but ok holds the decoder until stream end.
  function automatic void post_result(input status_e st, input logic [15:0] len);
    instr_res_t r;
    r.off = ins_start;
    r.op  = cur_op;
    r.len = len;
    r.st  = st;
    expected_instrs.push_back(r);
    ph = PH_IDLE;
    if (st != ST_OK) err_hold = 1'b1;
  endfunction

  // Check the bounds and work out the length of the jump table once the last bound word is in.
  function automatic void check_switch_bounds();
    longint lo_v;
    longint hi_v;
    longint nbytes;
    hi_v = longint'($signed(word_acc));
    if (cur_op == OP_TABLESWITCH) begin
      lo_v = longint'($signed(low_word));
      if (hi_v < lo_v) begin
        post_result(ST_BAD_BOUNDS, 16'd0);
        return;
      end
      nbytes = 4 * (hi_v - lo_v + 1);
    end else begin
      if (hi_v < 0) begin
        post_result(ST_BAD_BOUNDS, 16'd0);
        return;
      end
      nbytes = 8 * hi_v;
    end
    if (longint'(len_acc) + nbytes > longint'(CODE_LIMIT)) begin
      post_result(ST_BAD_BOUNDS, 16'd0);
    end else if (nbytes == 0) begin
      post_result(ST_OK, len_acc);
    end else begin
      tbl_left = 17'(nbytes);
      ph = PH_TABLE;
    end
  endfunction

  // Advance the predicted decoder by one accepted code word.
  function automatic void decode_step(input logic [7:0] b, input logic fin);
    logic [15:0] off;
    op_kind_e    k;
    int unsigned flen;
    logic [1:0]  pad;
    if (fin) begin
      if (!err_hold && ph != PH_IDLE) post_result(ST_TRUNCATED, 16'd0);
      restart_decoder();
      return;
    end
    off = run_off;
    run_off = off + 16'd1;
    if (err_hold) return;

    if (ph == PH_IDLE) begin
      ins_start = off;
      cur_op = b;
      len_acc = 16'd1;
      k = opcode_kind(b, flen);
      case (k)
        KIND_UNDEF: post_result(ST_UNDEF_OP, 16'd0);
        KIND_FIXED: begin
          if (flen == 1) begin
            post_result(ST_OK, 16'd1);
          end else begin
            fix_left = 4'(flen - 1);
            ph = PH_FIXED;
          end
        end
        KIND_NEWARRAY: ph = PH_NEWARRAY;
        KIND_WIDE: ph = PH_WIDE;
        default: begin
          // Switches pad up to the next multiple of four past the opcode.
          word_acc = '0;
          pad = ~off[1:0];
          if (pad != 2'd0) begin
            fix_left = {2'b00, pad};
            ph = PH_PAD;
          end else begin
            fix_left = 4'd4;
            ph = PH_DEF;
          end
        end
      endcase
      return;
    end

    len_acc = len_acc + 16'd1;
    case (ph)
      PH_FIXED: begin
        fix_left = fix_left - 4'd1;
        if (fix_left == 4'd0) post_result(ST_OK, len_acc);
      end
      PH_NEWARRAY: begin
        if (b >= ATYPE_FIRST && b <= ATYPE_LAST) post_result(ST_OK, len_acc);
        else post_result(ST_BAD_ATYPE, 16'd0);
      end
      PH_WIDE: begin
        if ((b >= OP_ILOAD && b <= OP_ALOAD) || (b >= OP_ISTORE && b <= OP_ASTORE) ||
            b == OP_RET) begin
          fix_left = 4'd2;
          ph = PH_FIXED;
        end else if (b == OP_IINC) begin
          fix_left = 4'd4;
          ph = PH_FIXED;
        end else begin
          post_result(ST_BAD_WIDE, 16'd0);
        end
      end
      PH_PAD: begin
        fix_left = fix_left - 4'd1;
        if (fix_left == 4'd0) begin
          fix_left = 4'd4;
          ph = PH_DEF;
        end
      end
      PH_DEF, PH_LOW, PH_HIGH: begin
        word_acc = {word_acc[23:0], b};
        fix_left = fix_left - 4'd1;
        if (fix_left == 4'd0) begin
          fix_left = 4'd4;
          if (ph == PH_DEF) begin
            ph = (cur_op == OP_TABLESWITCH) ? PH_LOW : PH_HIGH;
            word_acc = '0;
          end else if (ph == PH_LOW) begin
            low_word = word_acc;
            word_acc = '0;
            ph = PH_HIGH;
          end else begin
            fix_left = 4'd0;
            check_switch_bounds();
          end
        end
      end
      PH_TABLE: begin
        tbl_left = tbl_left - 17'd1;
        if (tbl_left == 17'd0) post_result(ST_OK, len_acc);
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  function automatic void report_failure(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Sender gap: none unless throttled, then mostly none, some short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    if (!throttle) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_opcode();
    int unsigned r;
    int unsigned flen;
    logic [7:0]  op;
    r = $urandom_range(0, 99);
    if (r < 6) return 8'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
    if (r < 11) return OP_TABLESWITCH;
    if (r < 16) return OP_LOOKUPSWITCH;
    if (r < 24) return OP_WIDE;
    if (r < 30) return OP_NEWARRAY;
    do op = 8'($urandom); while (opcode_kind(op, flen) != KIND_FIXED);
    return op;
  endfunction

  function automatic bound_mode_e pick_bound_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return BND_NORMAL;
    if (r < 80) return BND_EMPTY;
    if (r < 90) return BND_INVERTED;
    return BND_OVERSIZE;
  endfunction

  function automatic logic [15:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom_range(16'hFFF0, 16'hFFFF));
    return 16'($urandom);
  endfunction

  // Send one code word and update the prediction when it is taken.
  task automatic send_code(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      code_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    code_if.valid = 1'b1;
    code_if.code_byte = b;
    code_if.stream_end = fin;
    do @(posedge clk_i); while (!code_if.ready);
    if (!err_hold || fin) words_sent++;
    if (fin) streams_sent++;
    decode_step(b, fin);
  endtask

  // Stop sending until every predicted result is in, optionally letting the pipeline empty.
  task automatic wait_drained(input bit settle);
    @(negedge clk_i);
    code_if.valid = 1'b0;
    while (expected_instrs.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_offset(input logic [15:0] value);
    wait_drained(1'b1);
    @(negedge clk_i);
    start_offset_we = 1'b1;
    start_offset_val = value;
    @(posedge clk_i);
    start_reg = value;
    restart_decoder();
    offset_writes++;
    @(negedge clk_i);
    start_offset_we = 1'b0;
  endtask

  // One instruction that follows the opcode's layout; cut_rate is the per-mille chance per
  // operand word of ending the stream early instead.
  task automatic send_instruction(input logic [7:0] op, input bound_mode_e mode,
                                  input int cut_rate);
    logic [31:0] lo_w;
    logic [31:0] hi_w;
    logic [7:0]  atype;
    logic [7:0]  target;
    logic [7:0]  b;
    int unsigned r;

    atype = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(ATYPE_FIRST, ATYPE_LAST))
                                         : 8'($urandom);
    r = $urandom_range(0, 11);
    if (r < 5) target = OP_ILOAD + 8'(r);
    else if (r < 10) target = OP_ISTORE + 8'(r - 5);
    else if (r == 10) target = OP_RET;
    else target = OP_IINC;
    if ($urandom_range(0, 99) < 15) target = 8'($urandom);

    // Bound words: low and high for tableswitch, only the pair count for lookupswitch.
    lo_w = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 20)) - 32'd10;
    case (mode)
      BND_EMPTY: hi_w = (op == OP_TABLESWITCH) ? lo_w : 32'd0;
      BND_INVERTED: begin
        lo_w = $urandom_range(1, 1000);
        hi_w = (op == OP_TABLESWITCH) ? lo_w - $urandom_range(1, 2000)
                                      : {1'b1, 31'($urandom)};
      end
      BND_OVERSIZE: begin
        lo_w = $urandom_range(0, 100);
        hi_w = (op == OP_TABLESWITCH) ? lo_w + $urandom_range(16384, 32'h3FFF_FFFF)
                                      : $urandom_range(8192, 32'h7FFF_FFFF);
      end
      default: begin
        hi_w = (op == OP_TABLESWITCH) ? lo_w + $urandom_range(0, 3) : $urandom_range(1, 3);
      end
    endcase

    send_code(op, 1'b0);
    while (ph != PH_IDLE && !err_hold) begin
      if ($urandom_range(0, 999) < cut_rate) begin
        send_code(8'($urandom), 1'b1);
        return;
      end
      case (ph)
        PH_NEWARRAY: b = atype;
        PH_WIDE: b = target;
        PH_LOW: b = lo_w[8*fix_left-1 -: 8];
        PH_HIGH: b = hi_w[8*fix_left-1 -: 8];
        default: b = 8'($urandom);
      endcase
      send_code(b, 1'b0);
    end
  endtask

  // One-byte specials, newarray and wide forms, truncation, with offsets wrapping past 0xFFFF.
  task automatic test_directed_basics();
    throttle = 1'b1;
    write_start_offset(16'hFFFE);
    send_code(OP_NOP, 1'b0);
    send_code(OP_IMPDEP2, 1'b0);
    send_code(OP_IMPDEP1, 1'b0);
    send_code(OP_BREAKPOINT, 1'b0);
    send_code(OP_INVOKEDYNAMIC, 1'b0);
    send_code(OP_NEWARRAY, 1'b0);
    send_code(ATYPE_LAST, 1'b0);
    send_code(OP_WIDE, 1'b0);
    send_code(OP_IINC, 1'b0);
    repeat (4) send_code(8'($urandom), 1'b0);
    send_code(OP_WIDE, 1'b0);
    send_code(OP_ALOAD, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(OP_SIPUSH, 1'b0);
    send_code(8'hFF, 1'b1);
  endtask

  // Undef opcode, bad atype, bad wide; bytes held off until stream end; an end with nothing pending.
  task automatic test_error_hold();
    send_code(OP_UNDEF_FIRST, 1'b0);
    send_code(OP_NOP, 1'b0);
    send_code(8'($urandom), 1'b1);
    send_code(OP_NEWARRAY, 1'b0);
    send_code(ATYPE_LAST + 8'd1, 1'b0);
    send_code(8'($urandom), 1'b1);
    send_code(OP_WIDE, 1'b0);
    send_code(OP_NOP, 1'b0);
    send_code(OP_NOP, 1'b0);
    send_code(8'($urandom), 1'b1);
    send_code(8'h00, 1'b1);
  endtask

  // Both switches at every alignment and with every kind of bound, with no throttling of sender or sink.
  task automatic test_switch_layouts();
    logic [7:0] sw_op;
    throttle = 1'b0;
    write_start_offset(16'h0000);
    for (int pass = 0; pass < 2; pass++) begin
      sw_op = (pass == 0) ? OP_TABLESWITCH : OP_LOOKUPSWITCH;
      for (int pad = 0; pad < 4; pad++) begin
        // Nops move the opcode so that it is followed by the wanted pad count.
        repeat ((3 - pad - int'(run_off[1:0])) & 3) send_code(OP_NOP, 1'b0);
        send_instruction(sw_op, BND_NORMAL, 0);
      end
      if (pass == 0) wait_drained(1'b0);
      for (int m = 0; m < 4; m++) begin
        send_instruction(sw_op, bound_mode_e'(m), 0);
        if (err_hold) send_code(8'($urandom), 1'b1);
      end
      send_code(8'($urandom), 1'b1);
    end
    write_start_offset(16'hFFFF);
    send_instruction(OP_TABLESWITCH, BND_NORMAL, 0);
    send_instruction(OP_LOOKUPSWITCH, BND_NORMAL, 0);
    send_code(8'($urandom), 1'b1);
  endtask

  // Every opcode value once as a complete instruction.
  task automatic test_opcode_sweep();
    throttle = 1'b1;
    write_start_offset(16'($urandom));
    for (int op = 0; op < 256; op++) begin
      send_instruction(8'(op), BND_NORMAL, 0);
      if (err_hold) send_code(8'($urandom), 1'b1);
    end
    send_code(8'($urandom), 1'b1);
  endtask

  // Streams of instructions with random content, some malformed, some cut short, some pure noise.
  task automatic test_random_streams();
    int n_instr;
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 7) == 0) write_start_offset(pick_offset());
      throttle = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 16)) send_code(8'($urandom), 1'b0);
      end else begin
        n_instr = $urandom_range(1, 12);
        for (int i = 0; i < n_instr && !err_hold; i++) begin
          if ($urandom_range(0, 39) == 0) wait_drained(1'b0);
          send_instruction(pick_opcode(), pick_bound_mode(), 10);
        end
      end
      if (err_hold) repeat ($urandom_range(0, 3)) send_code(8'($urandom), 1'b0);
      send_code(8'($urandom), 1'b1);
    end
  endtask

  // Result sink: random stalls, mostly short and a few long, or always ready.
  initial begin
    int stall_left;
    int unsigned r;
    res_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (!throttle) begin
        res_if.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          res_if.ready = 1'b0;
          stall_left = (r < 2) ? $urandom_range(9, 39) : $urandom_range(0, 2);
        end else begin
          res_if.ready = 1'b1;
        end
      end
    end
  end

  // Compare each accepted result with the oldest predicted instruction.
  always @(posedge clk_i) begin
    instr_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (expected_instrs.size() == 0) begin
        report_failure($sformatf("unexpected result: off=%h op=%h len=%0d status=%0d",
                                 res_if.instr_offset, res_if.opcode, res_if.instr_length,
                                 res_if.status));
      end else begin
        want = expected_instrs.pop_front();
        if (res_if.instr_offset !== want.off || res_if.opcode !== want.op ||
            res_if.instr_length !== want.len || res_if.status !== want.st) begin
          report_failure($sformatf(
            "result %0d mismatch: expected off=%h op=%h len=%0d st=%0d, got off=%h op=%h len=%0d st=%0d",
            results_seen, want.off, want.op, want.len, want.st, res_if.instr_offset,
            res_if.opcode, res_if.instr_length, res_if.status));
        end else begin
          status_seen[int'(want.st)]++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((code_if.valid && code_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results still pending",
               idle_cycles, expected_instrs.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Reset, run the tests in turn, then report.
  initial begin
    code_if.valid = 1'b0;
    code_if.code_byte = 8'h00;
    code_if.stream_end = 1'b0;
    start_offset_we = 1'b0;
    start_offset_val = 16'h0000;
    throttle = 1'b1;
    rst_ni = 1'b0;
    start_reg = 16'h0000;
    restart_decoder();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_basics();
    test_error_hold();
    test_switch_layouts();
    test_opcode_sweep();
    test_random_streams();
    wait_drained(1'b1);

    $display("Covered %0d code words in %0d streams over %0d start offsets, all opcodes.",
             words_sent, streams_sent, offset_writes);
    $display("Checked %0d results: ok %0d, undef %0d, atype %0d, wide %0d, trunc %0d, bounds %0d",
             results_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("tb: errors");
    end
    $finish;
  end

endmodule
